/* rtl/onewire_rom_search_macros.svh */
// Assertion helpers used by the checker of the block.
`ifndef ONEWIRE_ROM_SEARCH_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define OWS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define OWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ows_pkg.sv */
`default_nettype none

package ows_pkg;

    localparam int ID_BITS   = 64;
    localparam int POS_W     = 7;
    localparam int OUT_DEPTH = 4;

    localparam logic [1:0] MODE_NEW  = 2'd0;
    localparam logic [1:0] MODE_PASS = 2'd1;
    localparam logic [1:0] MODE_PAIR = 2'd2;

    localparam logic [2:0] KIND_CMD   = 3'd0;
    localparam logic [2:0] KIND_DIR   = 3'd1;
    localparam logic [2:0] KIND_FOUND = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_PRESENCE = 3'd1;
    localparam logic [2:0] ERR_BOTH_ONE = 3'd2;
    localparam logic [2:0] ERR_CRC      = 3'd3;
    localparam logic [2:0] ERR_CAPACITY = 3'd4;

    localparam logic [1:0] CFG_ALARM_SEARCH   = 2'd0;
    localparam logic [1:0] CFG_SEARCH_COMMAND = 2'd1;
    localparam logic [1:0] CFG_ALARM_COMMAND  = 2'd2;
    localparam logic [1:0] CFG_MAX_DEVICES    = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PASS  = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;
    localparam logic [1:0] PH_ERROR = 2'd3;

    localparam logic [7:0] RST_SEARCH_COMMAND = 8'hF0;
    localparam logic [7:0] RST_ALARM_COMMAND  = 8'hEC;
    localparam logic [7:0] RST_MAX_DEVICES    = 8'hFF;
    localparam logic [7:0] FOUND_MAX          = 8'hFF;
    localparam logic [7:0] CRC_POLY           = 8'h8C;

    typedef struct packed {
        logic [1:0] mode;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } t_request;

    typedef struct packed {
        logic       valid;
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         command_byte;
        logic               direction;
        logic [ID_BITS-1:0] rom_id;
        logic [7:0]         device_count;
        logic [2:0]         error_code;
        logic               stored;
        logic               last;
    } t_result;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic bit_in);
        logic fb;
        fb = crc[0] ^ bit_in;
        return (crc >> 1) ^ (fb ? CRC_POLY : 8'h00);
    endfunction

    function automatic t_result make_result(
        input logic [2:0]         kind,
        input logic [7:0]         cmd,
        input logic               dir,
        input logic [ID_BITS-1:0] id,
        input logic [7:0]         cnt,
        input logic [2:0]         err,
        input logic               st,
        input logic               lst
    );
        t_result r;
        r.kind         = kind;
        r.command_byte = cmd;
        r.direction    = dir;
        r.rom_id       = id;
        r.device_count = cnt;
        r.error_code   = err;
        r.stored       = st;
        r.last         = lst;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ows_engine.sv */
`default_nettype none

module ows_engine (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  ows_pkg::t_request    i_req,
    input  ows_pkg::t_cfg_write  i_cfg,
    output logic [1:0]           o_count,
    output ows_pkg::t_result     o_res0,
    output ows_pkg::t_result     o_res1
);
    import ows_pkg::*;

    logic               r_alarm_search, n_alarm_search;
    logic [7:0]         r_search_cmd, n_search_cmd;
    logic [7:0]         r_alarm_cmd, n_alarm_cmd;
    logic [7:0]         r_max_dev, n_max_dev;

    logic [1:0]         r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_last_disc, n_last_disc;
    logic [POS_W-1:0]   r_last_zero, n_last_zero;
    logic [ID_BITS-1:0] r_cur_id, n_cur_id;
    logic [ID_BITS-1:0] r_prev_id, n_prev_id;
    logic               r_final, n_final;
    logic [7:0]         r_found, n_found;
    logic [7:0]         r_crc, n_crc;

    logic [5:0]         w_sh;
    logic               w_both_zero;
    logic               w_dir;
    logic [POS_W-1:0]   w_last_zero;
    logic [ID_BITS-1:0] w_cur_id;
    logic [7:0]         w_crc;
    logic               w_last_bit;
    logic [7:0]         w_cmd;

    always_comb begin
        w_sh        = 6'(r_pos - POS_W'(1));
        w_both_zero = !i_req.id_bit && !i_req.complement_bit;
        if (!w_both_zero) begin
            w_dir = i_req.id_bit;
        end else if (r_pos == r_last_disc) begin
            w_dir = 1'b1;
        end else if (r_pos > r_last_disc) begin
            w_dir = 1'b0;
        end else begin
            w_dir = r_prev_id[w_sh];
        end
        w_last_zero       = (w_both_zero && !w_dir) ? r_pos : r_last_zero;
        w_cur_id          = r_cur_id;
        w_cur_id[w_sh]    = r_cur_id[w_sh] | w_dir;
        w_crc             = crc_step(r_crc, w_dir);
        w_last_bit        = (r_pos == POS_W'(ID_BITS));
        w_cmd             = r_alarm_search ? r_alarm_cmd : r_search_cmd;
    end

    always_comb begin
        n_alarm_search = r_alarm_search;
        n_search_cmd   = r_search_cmd;
        n_alarm_cmd    = r_alarm_cmd;
        n_max_dev      = r_max_dev;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ALARM_SEARCH:   n_alarm_search = i_cfg.data[0];
                CFG_SEARCH_COMMAND: n_search_cmd   = i_cfg.data;
                CFG_ALARM_COMMAND:  n_alarm_cmd    = i_cfg.data;
                CFG_MAX_DEVICES:    n_max_dev      = i_cfg.data;
                default:            ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_last_disc = r_last_disc;
        n_last_zero = r_last_zero;
        n_cur_id    = r_cur_id;
        n_prev_id   = r_prev_id;
        n_final     = r_final;
        n_found     = r_found;
        n_crc       = r_crc;
        o_count     = 2'd0;
        o_res0      = '0;
        o_res1      = '0;
        if (i_accept) begin
            unique case (i_req.mode)
                MODE_NEW: begin
                    n_phase     = PH_IDLE;
                    n_pos       = POS_W'(1);
                    n_last_disc = '0;
                    n_last_zero = '0;
                    n_cur_id    = '0;
                    n_prev_id   = '0;
                    n_final     = 1'b0;
                    n_found     = '0;
                    n_crc       = '0;
                end
                MODE_PASS: begin
                    if (r_phase != PH_ERROR) begin
                        o_count = 2'd1;
                        if (r_max_dev == 8'd0) begin
                            n_phase = PH_ERROR;
                            o_res0  = make_result(KIND_ERROR, 8'd0, 1'b0, '0, r_found,
                                                  ERR_CAPACITY, 1'b0, 1'b1);
                        end else if (!i_req.presence) begin
                            n_phase = PH_ERROR;
                            o_res0  = make_result(KIND_ERROR, 8'd0, 1'b0, '0, r_found,
                                                  ERR_PRESENCE, 1'b0, 1'b1);
                        end else if (r_final) begin
                            n_phase = PH_DONE;
                            o_res0  = make_result(KIND_DONE, 8'd0, 1'b0, '0, r_found,
                                                  ERR_NONE, 1'b0, 1'b1);
                        end else begin
                            n_phase     = PH_PASS;
                            n_pos       = POS_W'(1);
                            n_last_zero = '0;
                            n_cur_id    = '0;
                            n_crc       = '0;
                            o_res0      = make_result(KIND_CMD, w_cmd, 1'b0, '0, r_found,
                                                      ERR_NONE, 1'b0, 1'b1);
                        end
                    end
                end
                MODE_PAIR: begin
                    if (r_phase == PH_PASS) begin
                        if (i_req.id_bit && i_req.complement_bit) begin
                            n_phase = PH_ERROR;
                            o_count = 2'd1;
                            o_res0  = make_result(KIND_ERROR, 8'd0, 1'b0, '0, r_found,
                                                  ERR_BOTH_ONE, 1'b0, 1'b1);
                        end else begin
                            n_last_zero = w_last_zero;
                            n_cur_id    = w_cur_id;
                            n_crc       = w_crc;
                            if (!w_last_bit) begin
                                n_pos   = r_pos + POS_W'(1);
                                o_count = 2'd1;
                                o_res0  = make_result(KIND_DIR, 8'd0, w_dir, '0, r_found,
                                                      ERR_NONE, 1'b0, 1'b1);
                            end else begin
                                o_count     = 2'd2;
                                o_res0      = make_result(KIND_DIR, 8'd0, w_dir, '0,
                                                          r_found, ERR_NONE, 1'b0, 1'b0);
                                n_last_disc = w_last_zero;
                                n_final     = (w_last_zero == '0);
                                n_pos       = POS_W'(1);
                                if (w_crc != 8'd0) begin
                                    n_phase = PH_ERROR;
                                    o_res1  = make_result(KIND_ERROR, 8'd0, 1'b0, '0,
                                                          r_found, ERR_CRC, 1'b0, 1'b1);
                                end else begin
                                    n_phase   = PH_IDLE;
                                    n_prev_id = w_cur_id;
                                    n_found   = (r_found != FOUND_MAX) ?
                                                r_found + 8'd1 : r_found;
                                    o_res1    = make_result(KIND_FOUND, 8'd0, 1'b0,
                                                            w_cur_id, n_found, ERR_NONE,
                                                            r_found < r_max_dev, 1'b1);
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_search <= 1'b0;
            r_search_cmd   <= RST_SEARCH_COMMAND;
            r_alarm_cmd    <= RST_ALARM_COMMAND;
            r_max_dev      <= RST_MAX_DEVICES;
            r_phase        <= PH_IDLE;
            r_pos          <= POS_W'(1);
            r_last_disc    <= '0;
            r_last_zero    <= '0;
            r_cur_id       <= '0;
            r_prev_id      <= '0;
            r_final        <= 1'b0;
            r_found        <= '0;
            r_crc          <= '0;
        end else begin
            r_alarm_search <= n_alarm_search;
            r_search_cmd   <= n_search_cmd;
            r_alarm_cmd    <= n_alarm_cmd;
            r_max_dev      <= n_max_dev;
            r_phase        <= n_phase;
            r_pos          <= n_pos;
            r_last_disc    <= n_last_disc;
            r_last_zero    <= n_last_zero;
            r_cur_id       <= n_cur_id;
            r_prev_id      <= n_prev_id;
            r_final        <= n_final;
            r_found        <= n_found;
            r_crc          <= n_crc;
        end
    end

endmodule

`default_nettype wire

/* rtl/ows_out_queue.sv */
`default_nettype none

module ows_out_queue #(
    parameter int DEPTH = ows_pkg::OUT_DEPTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [1:0]                   i_push_count,
    input  ows_pkg::t_result             i_entry0,
    input  ows_pkg::t_result             i_entry1,
    input  wire                          i_pop,
    output ows_pkg::t_result             o_head,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import ows_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   w_wr_next;

    always_comb begin
        w_wr_next = r_wr + PW'(1);
        n_wr      = r_wr + PW'(i_push_count);
        n_rd      = i_pop ? r_rd + PW'(1) : r_rd;
        n_count   = r_count + CW'(i_push_count) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_entry0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[w_wr_next] <= i_entry1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

`default_nettype wire

/* rtl/onewire_rom_search.sv */
// ROM search decision engine for a one-wire bus master.
// Request channel: i_in_valid / o_in_stall with i_mode (new search, pass start,
// bit pair), i_presence, i_id_bit and i_complement_bit. A request is taken at an
// edge where i_in_valid is high and o_in_stall is low.
// Result channel: o_out_valid / i_out_stall with kind, command byte, direction,
// ROM id, device count, error code, stored and last.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// o_cfg_ready is always high. Write only while no results are outstanding.
// The results of a request enter the result queue at the edge that takes it.
// Throughput: one request per cycle while o_in_stall is low; the 64th bit pair
// gives two results. The decision logic runs in the cycle of acceptance and
// fills a result queue of OUT_DEPTH entries; the request side stalls while the
// queue holds more than OUT_DEPTH-2 results.
// A stalled result holds its fields until taken; requests keep flowing while
// the queue has room. OUT_DEPTH is a power of two, at least 4.
// Reset clears the search state, restores the register defaults and empties
// the queue.
`default_nettype none

module onewire_rom_search #(
    parameter int OUT_DEPTH = ows_pkg::OUT_DEPTH
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  [1:0]                  i_mode,
    input  wire                         i_presence,
    input  wire                         i_id_bit,
    input  wire                         i_complement_bit,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [2:0]                  o_kind,
    output logic [7:0]                  o_command_byte,
    output logic                        o_direction,
    output logic [ows_pkg::ID_BITS-1:0] o_rom_id,
    output logic [7:0]                  o_device_count,
    output logic [2:0]                  o_error_code,
    output logic                        o_stored,
    output logic                        o_last,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [1:0]                  i_cfg_index,
    input  wire  [7:0]                  i_cfg_data
);
    import ows_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);

    t_request        w_req;
    t_cfg_write      w_cfg;
    t_result         w_res0, w_res1, w_head;
    logic [1:0]      w_push_count;
    logic [CW-1:0]   w_queue_count;
    logic            w_accept;
    logic            w_pop;

    assign w_req.mode           = i_mode;
    assign w_req.presence       = i_presence;
    assign w_req.id_bit         = i_id_bit;
    assign w_req.complement_bit = i_complement_bit;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid & o_cfg_ready;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    assign o_in_stall  = (w_queue_count > CW'(OUT_DEPTH - 2));
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = (w_queue_count != '0);
    assign w_pop       = o_out_valid & ~i_out_stall;

    ows_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_req   (w_req),
        .i_cfg   (w_cfg),
        .o_count (w_push_count),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    ows_out_queue #(
        .DEPTH(OUT_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_count(w_push_count),
        .i_entry0    (w_res0),
        .i_entry1    (w_res1),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_count     (w_queue_count)
    );

    assign o_kind         = w_head.kind;
    assign o_command_byte = w_head.command_byte;
    assign o_direction    = w_head.direction;
    assign o_rom_id       = w_head.rom_id;
    assign o_device_count = w_head.device_count;
    assign o_error_code   = w_head.error_code;
    assign o_stored       = w_head.stored;
    assign o_last         = w_head.last;

endmodule

`default_nettype wire

/* rtl/ows_checker.sv */
`default_nettype none
`include "onewire_rom_search_macros.svh"

module ows_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         o_in_stall,
    input wire  [1:0]                  i_mode,
    input wire                         i_presence,
    input wire                         i_id_bit,
    input wire                         i_complement_bit,
    input wire                         o_out_valid,
    input wire                         i_out_stall,
    input wire  [2:0]                  o_kind,
    input wire  [7:0]                  o_command_byte,
    input wire                         o_direction,
    input wire  [ows_pkg::ID_BITS-1:0] o_rom_id,
    input wire  [7:0]                  o_device_count,
    input wire  [2:0]                  o_error_code,
    input wire                         o_stored,
    input wire                         o_last,
    input wire                         i_cfg_valid,
    input wire                         o_cfg_ready,
    input wire  [1:0]                  i_cfg_index,
    input wire  [7:0]                  i_cfg_data
);
    import ows_pkg::*;

    `OWS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_rom_id) && $stable(o_last), "stalled result changed")
    `OWS_ASSERT_IMPL(a_err_code, o_out_valid, (o_kind == KIND_ERROR) == (o_error_code != ERR_NONE), "error code does not match kind")
    `OWS_ASSERT_IMPL(a_last_mark, o_out_valid && o_kind != KIND_DIR, o_last, "only a direction may precede another result")
    `OWS_ASSERT_IMPL(a_found_only, o_out_valid && o_kind != KIND_FOUND, o_rom_id == '0 && !o_stored, "id or stored flag outside a found result")

endmodule

bind onewire_rom_search ows_checker u_ows_checker (.*);

`default_nettype wire
